// ===== sv/bmf_pkg.sv =====
`default_nettype none

package bmf_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_MAX_RADIUS = 12;

    localparam int CNT_W   = 24;   // item counter width
    localparam int CFG_W   = 12;   // width and height register width
    localparam int RAD_W   = 4;    // radius register width
    localparam int PIX_W   = 8;    // one color channel
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;
    localparam logic [RAD_W-1:0] RST_RADIUS = 4'd3;

    // Control from the sequencer to each channel lane.
    typedef struct packed {
        logic clear;
        logic acc;
        logic start;
    } bmf_lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/bmf_ram.sv =====
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bmf_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle; done pulses when the result is ready.
module bmf_div
    import bmf_pkg::*;
#(
    parameter int DW = 24,
    parameter int VW = 12
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic      [DW-1:0] quot,
    output logic      [VW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quot_reg, quot_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quot_reg[DW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            rem_next  = ge ? diff[VW-1:0] : trial[VW-1:0];
            quot_next = {quot_reg[DW-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== sv/bmf_lane.sv =====
`default_nettype none

// One color channel: accumulates the window and divides by its area.
module bmf_lane
    import bmf_pkg::*;
#(
    parameter int AREA_W = 10,
    parameter int SUM_W  = PIX_W + AREA_W
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bmf_lane_ctl_t     ctl,
    input  wire logic [PIX_W-1:0]  pix,
    input  wire logic [AREA_W-1:0] area,
    output logic                   done,
    output logic      [PIX_W-1:0]  mean
);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  quot;
    logic [AREA_W-1:0] rem;

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            sum_reg <= '0;
        end else if (ctl.acc) begin
            sum_reg <= sum_reg + SUM_W'(pix);
        end
    end

    bmf_div #(
        .DW (SUM_W),
        .VW (AREA_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.start),
        .dividend (sum_reg),
        .divisor  (area),
        .done     (done),
        .quot     (quot),
        .rem      (rem)
    );

    // The mean never exceeds one channel's range; the remainder is not needed.
    assign mean = quot[PIX_W-1:0] | (rem[0] & 1'b0 ? '1 : '0);

endmodule

`default_nettype wire

// ===== sv/box_mean_image_filter.sv =====
// Box mean filter for a streamed RGB frame with replicated borders.
// Pixels enter on the s_ channel (valid/ready) in raster order; each item is
// either a pixel (s_func = 0) or a drain tick (s_func = 1). The result for
// raster position k leaves on the m_ channel with the item that brings the
// frame's item count to k + r*W + r + 1, so the sender appends r*W + r drain
// items after the last pixel. m_frame_last marks the final pixel of a frame.
// Frame width, height and window radius are set through the APB port; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Reset loads 640 x 480 with radius 3. Items are handled
// one at a time. An item that stores a pixel uses the bit-serial divider to
// turn the item count into row and column before the write. An item that
// also yields a result then has the window read from the line store one
// pixel per cycle while three channel lanes accumulate, then each lane
// divides by the window area. An item past the frame's last pixel position
// skips the store and goes straight to the conversion for its result.
// A finished result waits in the output register while the receiver stalls;
// the block takes the next item meanwhile and only holds it before its own
// result when the register is still full. Reset clears the counters and the
// output valid; the line store needs no clearing pass.
`default_nettype none

module box_mean_image_filter
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_func,
    input  wire logic [PIX_W-1:0]   s_in_blue,
    input  wire logic [PIX_W-1:0]   s_in_green,
    input  wire logic [PIX_W-1:0]   s_in_red,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [PIX_W-1:0]   m_out_blue,
    output logic      [PIX_W-1:0]   m_out_green,
    output logic      [PIX_W-1:0]   m_out_red,
    output logic                    m_frame_last
);

    // Line store holds the last 2*MAX_RADIUS+2 rows, one row per slot.
    localparam int ROWS   = 2 * MAX_RADIUS + 2;
    localparam int DEPTH  = ROWS * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(ROWS);
    localparam int AREA_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W  = PIX_W + AREA_W;
    localparam int RGB_W  = 3 * PIX_W;
    localparam int D_W    = RAD_W + 1;

    // Reciprocal of ROWS, exact for every row number that fits CFG_W bits.
    localparam int RECIP_S = 24;
    localparam int RECIP   = (2 ** RECIP_S + ROWS - 1) / ROWS;
    localparam int PROD_W  = CFG_W + RECIP_S;

    typedef enum logic [3:0] {
        S_IDLE, S_GEOM, S_COUNT, S_WDIV, S_WQUOT, S_WSLOT, S_KDIV, S_RQUOT,
        S_SLOT, S_READ, S_FLUSH, S_MSTART, S_MWAIT, S_OUT
    } st_t;

    // Configuration registers.
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [RAD_W-1:0] window_radius_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= RST_WIDTH;
            frame_height_reg  <= RST_HEIGHT;
            window_radius_reg <= RST_RADIUS;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  frame_width_reg   <= pwdata[CFG_W-1:0];
                REG_HEIGHT: frame_height_reg  <= pwdata[CFG_W-1:0];
                REG_RADIUS: window_radius_reg <= pwdata[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            REG_RADIUS: prdata = PDATA_W'(window_radius_reg);
            default:    prdata = '0;
        endcase
    end

    // Register values clamped to the supported range.
    logic [CFG_W-1:0] w_eff, h_eff;
    logic [RAD_W-1:0] r_eff;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = CFG_W'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = frame_width_reg;
        end
        if (frame_height_reg == '0) begin
            h_eff = CFG_W'(1);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = frame_height_reg;
        end
        if (32'(window_radius_reg) > 32'(MAX_RADIUS)) begin
            r_eff = RAD_W'(MAX_RADIUS);
        end else begin
            r_eff = window_radius_reg;
        end
    end

    // Sequencer state.
    st_t               state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              func_reg, func_next;
    logic [RGB_W-1:0]  pix_reg, pix_next;
    logic [CFG_W-1:0]  w_reg, w_next;
    logic [CFG_W-1:0]  h_reg, h_next;
    logic [RAD_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  pixels_reg, pixels_next;
    logic [CNT_W-1:0]  lag_reg, lag_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic              produce_reg, produce_next;
    logic              last_reg, last_next;
    logic [CFG_W-1:0]  wcol_reg, wcol_next;
    logic [CFG_W-1:0]  x_reg, x_next;
    logic [CFG_W-1:0]  y_reg, y_next;
    logic [CFG_W-1:0]  ky_reg, ky_next;
    logic [CFG_W-1:0]  row_reg, row_next;
    logic [CFG_W-1:0]  rq_reg, rq_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [D_W-1:0]    dx_reg, dx_next;
    logic [D_W-1:0]    dy_reg, dy_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]  m_blue_reg, m_blue_next;
    logic [PIX_W-1:0]  m_green_reg, m_green_next;
    logic [PIX_W-1:0]  m_red_reg, m_red_next;
    logic              m_last_reg, m_last_next;

    // Shared divider for the count-to-coordinate conversions.
    logic             div_start;
    logic [CNT_W-1:0] div_dividend;
    logic [CFG_W-1:0] div_divisor;
    logic             div_done;
    logic [CNT_W-1:0] div_quot;
    logic [CFG_W-1:0] div_rem;

    bmf_div #(
        .DW (CNT_W),
        .VW (CFG_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Row to line-store slot. The quotient row / ROWS comes from a reciprocal
    // multiply and is registered; one constant multiply and a subtract then
    // give the remainder in the following cycle.
    logic [PROD_W-1:0] row_prod;
    logic [CFG_W-1:0]  row_quot, row_left;
    logic [SLOT_W-1:0] row_slot;

    assign row_prod = PROD_W'(row_reg) * PROD_W'(RECIP);
    assign row_quot = row_prod[PROD_W-1:RECIP_S];
    assign row_left = row_reg - CFG_W'(rq_reg * CFG_W'(ROWS));
    assign row_slot = row_left[SLOT_W-1:0];

    // Line store.
    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [RGB_W-1:0] ram_wdata, ram_rdata;

    bmf_ram #(
        .WIDTH (RGB_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Channel lanes and the merging of their means.
    bmf_lane_ctl_t    lane_ctl;
    logic [2:0]       lane_done;
    logic [PIX_W-1:0] mean_blue, mean_green, mean_red;

    bmf_lane #(.AREA_W(AREA_W), .SUM_W(SUM_W)) u_lane_blue (
        .aclk (aclk), .aresetn (aresetn), .ctl (lane_ctl),
        .pix (ram_rdata[PIX_W-1:0]), .area (area_reg),
        .done (lane_done[0]), .mean (mean_blue)
    );

    bmf_lane #(.AREA_W(AREA_W), .SUM_W(SUM_W)) u_lane_green (
        .aclk (aclk), .aresetn (aresetn), .ctl (lane_ctl),
        .pix (ram_rdata[2*PIX_W-1:PIX_W]), .area (area_reg),
        .done (lane_done[1]), .mean (mean_green)
    );

    bmf_lane #(.AREA_W(AREA_W), .SUM_W(SUM_W)) u_lane_red (
        .aclk (aclk), .aresetn (aresetn), .ctl (lane_ctl),
        .pix (ram_rdata[3*PIX_W-1:2*PIX_W]), .area (area_reg),
        .done (lane_done[2]), .mean (mean_red)
    );

    // Frame totals and window geometry, computed from the registered values.
    logic [CNT_W:0]   n_ext, total_ext, lag_ext;
    logic [CFG_W:0]   xs, ys, ky0_ext;
    logic [CFG_W:0]   xt, yt;
    logic [CFG_W-1:0] kx, ky_row, ky0;
    logic [D_W-1:0]   side_last;
    logic [5:0]       side;

    assign n_ext     = {1'b0, pos_reg} + (CNT_W + 1)'(1);
    assign lag_ext   = {1'b0, lag_reg};
    assign total_ext = {1'b0, pixels_reg} + lag_ext;
    assign side_last = {r_reg, 1'b0};
    assign side      = {1'b0, r_reg, 1'b1};

    // Column of the current read, clamped to the frame.
    assign xs = {1'b0, x_reg} + (CFG_W + 1)'(dx_reg);
    assign xt = xs - (CFG_W + 1)'(r_reg);
    always_comb begin
        if (xs < (CFG_W + 1)'(r_reg)) begin
            kx = '0;
        end else if (xt > (CFG_W + 1)'(w_reg - CFG_W'(1))) begin
            kx = w_reg - CFG_W'(1);
        end else begin
            kx = xt[CFG_W-1:0];
        end
    end

    // Row of the next window line, clamped to the frame.
    assign ys = {1'b0, y_reg} + (CFG_W + 1)'(dy_reg) + (CFG_W + 1)'(1);
    assign yt = ys - (CFG_W + 1)'(r_reg);
    always_comb begin
        if (ys < (CFG_W + 1)'(r_reg)) begin
            ky_row = '0;
        end else if (yt > (CFG_W + 1)'(h_reg - CFG_W'(1))) begin
            ky_row = h_reg - CFG_W'(1);
        end else begin
            ky_row = yt[CFG_W-1:0];
        end
    end

    // First window row for the result now being converted.
    assign ky0_ext = {1'b0, div_quot[CFG_W-1:0]} - (CFG_W + 1)'(r_reg);
    assign ky0     = (div_quot[CFG_W-1:0] < CFG_W'(r_reg)) ? '0 : ky0_ext[CFG_W-1:0];

    assign ram_raddr = AW'(AW'(slot_reg) * AW'(MAX_WIDTH) + AW'(kx));
    assign ram_waddr = AW'(AW'(row_slot) * AW'(MAX_WIDTH) + AW'(wcol_reg));
    assign ram_wdata = func_reg ? '0 : pix_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        func_next    = func_reg;
        pix_next     = pix_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        r_next       = r_reg;
        pixels_next  = pixels_reg;
        lag_next     = lag_reg;
        area_next    = area_reg;
        k_next       = k_reg;
        produce_next = produce_reg;
        last_next    = last_reg;
        wcol_next    = wcol_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        ky_next      = ky_reg;
        row_next     = row_reg;
        rq_next      = rq_reg;
        slot_next    = slot_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        rd_pend_next = 1'b0;
        m_valid_next = m_valid_reg & ~m_ready;
        m_blue_next  = m_blue_reg;
        m_green_next = m_green_reg;
        m_red_next   = m_red_reg;
        m_last_next  = m_last_reg;

        div_start    = 1'b0;
        div_dividend = pos_reg;
        div_divisor  = w_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        lane_ctl     = '0;
        lane_ctl.acc = rd_pend_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    pos_next   = count_reg;
                    func_next  = s_func;
                    pix_next   = {s_in_red, s_in_green, s_in_blue};
                    state_next = S_GEOM;
                end
            end
            S_GEOM: begin
                w_next      = w_eff;
                h_next      = h_eff;
                r_next      = r_eff;
                pixels_next = CNT_W'(w_eff) * CNT_W'(h_eff);
                lag_next    = CNT_W'(CNT_W'(r_eff) * CNT_W'(w_eff) + CNT_W'(r_eff));
                state_next  = S_COUNT;
            end
            S_COUNT: begin
                area_next    = AREA_W'(AREA_W'(side) * AREA_W'(side));
                k_next       = pos_reg - lag_reg;
                produce_next = (pos_reg >= lag_reg) && ((pos_reg - lag_reg) < pixels_reg);
                last_next    = (pos_reg - lag_reg) == (pixels_reg - CNT_W'(1));
                count_next   = (n_ext >= total_ext) ? '0 : n_ext[CNT_W-1:0];
                if (pos_reg < pixels_reg) begin
                    div_start  = 1'b1;
                    state_next = S_WDIV;
                end else if ((pos_reg >= lag_reg) && ((pos_reg - lag_reg) < pixels_reg)) begin
                    div_start    = 1'b1;
                    div_dividend = pos_reg - lag_reg;
                    state_next   = S_KDIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_WDIV: begin
                if (div_done) begin
                    wcol_next  = div_rem;
                    row_next   = div_quot[CFG_W-1:0];
                    state_next = S_WQUOT;
                end
            end
            S_WQUOT: begin
                rq_next    = row_quot;
                state_next = S_WSLOT;
            end
            S_WSLOT: begin
                ram_we       = 1'b1;
                div_dividend = k_reg;
                if (produce_reg) begin
                    div_start  = 1'b1;
                    state_next = S_KDIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_KDIV: begin
                if (div_done) begin
                    y_next     = div_quot[CFG_W-1:0];
                    x_next     = div_rem;
                    ky_next    = ky0;
                    row_next   = ky0;
                    state_next = S_RQUOT;
                end
            end
            S_RQUOT: begin
                rq_next    = row_quot;
                state_next = S_SLOT;
            end
            S_SLOT: begin
                slot_next      = row_slot;
                dx_next        = '0;
                dy_next        = '0;
                lane_ctl.clear = 1'b1;
                state_next     = S_READ;
            end
            S_READ: begin
                ram_re       = 1'b1;
                rd_pend_next = 1'b1;
                if (dx_reg == side_last) begin
                    dx_next = '0;
                    if (dy_reg == side_last) begin
                        state_next = S_FLUSH;
                    end else begin
                        dy_next = dy_reg + D_W'(1);
                        if (ky_row != ky_reg) begin
                            ky_next   = ky_row;
                            slot_next = (32'(slot_reg) == ROWS - 1) ? '0
                                                                    : slot_reg + SLOT_W'(1);
                        end
                    end
                end else begin
                    dx_next = dx_reg + D_W'(1);
                end
            end
            S_FLUSH: begin
                state_next = S_MSTART;
            end
            S_MSTART: begin
                lane_ctl.start = 1'b1;
                state_next     = S_MWAIT;
            end
            S_MWAIT: begin
                if (&lane_done) begin
                    m_blue_next  = mean_blue;
                    m_green_next = mean_green;
                    m_red_next   = mean_red;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_last_next  = last_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The mean registers are loaded before the output register
    // and only reach the port through it.
    logic [PIX_W-1:0] out_blue_reg, out_green_reg, out_red_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg     <= pos_next;
        func_reg    <= func_next;
        pix_reg     <= pix_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        r_reg       <= r_next;
        pixels_reg  <= pixels_next;
        lag_reg     <= lag_next;
        area_reg    <= area_next;
        k_reg       <= k_next;
        produce_reg <= produce_next;
        last_reg    <= last_next;
        wcol_reg    <= wcol_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        ky_reg      <= ky_next;
        row_reg     <= row_next;
        rq_reg      <= rq_next;
        slot_reg    <= slot_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        m_blue_reg  <= m_blue_next;
        m_green_reg <= m_green_next;
        m_red_reg   <= m_red_next;
        m_last_reg  <= m_last_next;
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            out_blue_reg  <= m_blue_reg;
            out_green_reg <= m_green_reg;
            out_red_reg   <= m_red_reg;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_out_blue   = out_blue_reg;
    assign m_out_green  = out_green_reg;
    assign m_out_red    = out_red_reg;
    assign m_frame_last = m_last_reg;

endmodule

`default_nettype wire
